// ----- rtl/sed_pkg.sv -----
package sed_pkg;

   // Decoder modes held by the front end
   typedef enum logic [3:0] {
      MODE_PLAIN,
      MODE_ESC,
      MODE_CR,
      MODE_OCT,
      MODE_HEXX,
      MODE_HEXU,
      MODE_DISCARD
   } mode_type;

   // Result error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_HEX  = 2'd1;
   localparam logic [1:0] ERR_CUT  = 2'd2;

   // Most results one input item can cause
   localparam int MAX_BYTES = 4;

   // Queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Work for the back end: up to four decoded bytes, then an optional
   // status result (end of string and/or error)
   typedef struct packed {
      logic [2:0]                  num_bytes;
      logic [MAX_BYTES-1:0][7:0]   data;
      logic                        tail_valid;
      logic                        tail_done;
      logic [1:0]                  tail_error;
   } bundle_type;

endpackage

// ----- rtl/sed_req_if.sv -----
interface sed_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] in_byte;

   modport source (output valid, output kind, output in_byte, input ready);
   modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

// ----- rtl/sed_rsp_if.sv -----
interface sed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       string_done;
   logic [1:0] error_code;

   modport source (output valid, output out_byte, output has_byte, output string_done,
                   output error_code, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input string_done,
                   input error_code, output ready);
endinterface

// ----- rtl/sed_front.sv -----
module sed_front (
   input  logic                clock,
   input  logic                reset,
   sed_req_if.sink             req_chan,
   input  logic                q_full,
   output logic                q_push,
   output sed_pkg::bundle_type q_data
);
   import sed_pkg::*;

   // Byte codes the decoder looks for
   localparam logic [7:0] CH_LF        = 8'h0a;
   localparam logic [7:0] CH_CR        = 8'h0d;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_UP_A      = 8'h41;
   localparam logic [7:0] CH_UP_F      = 8'h46;
   localparam logic [7:0] CH_LO_A      = 8'h61;
   localparam logic [7:0] CH_LO_F      = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_A         = 8'h61;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_V         = 8'h76;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_LO_U      = 8'h75;
   localparam logic [7:0] CH_UP_U      = 8'h55;

   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  digits_ff, digits_in;
   logic        accept;
   bundle_type  bundle;

   // Hex digit value, bit 4 set when the byte is a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] res;
      res = 5'd0;
      if (b >= CH_ZERO && b <= CH_NINE)
         res = {1'b1, 4'(b - CH_ZERO)};
      else if (b >= CH_UP_A && b <= CH_UP_F)
         res = {1'b1, 4'(b - CH_UP_A + 8'd10)};
      else if (b >= CH_LO_A && b <= CH_LO_F)
         res = {1'b1, 4'(b - CH_LO_A + 8'd10)};
      return res;
   endfunction

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   // Classify one item: next decoder state and the results it causes
   always_comb begin
      logic [7:0]  b;
      logic [2:0]  n;
      logic [4:0]  hv;
      logic [31:0] u;
      logic [3:0]  dig_dec;
      logic [7:0]  oct_val;

      b       = req_chan.in_byte;
      n       = 3'd0;
      hv      = hex_value(b);
      u       = {acc_ff[27:0], hv[3:0]};
      dig_dec = digits_ff - 4'd1;
      oct_val = {acc_ff[4:0], 3'(b - CH_ZERO)};

      mode_in   = mode_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      bundle    = '0;

      if (req_chan.kind) begin
         // end of string: flush any open escape, then clear state
         case (mode_ff)
            MODE_ESC, MODE_HEXX, MODE_HEXU: begin
               bundle.tail_error = ERR_CUT;
            end
            MODE_OCT: begin
               bundle.data[0] = acc_ff[7:0];
               n = 3'd1;
            end
            default: begin
            end
         endcase
         bundle.tail_valid = 1'b1;
         bundle.tail_done  = 1'b1;
         mode_in   = MODE_PLAIN;
         acc_in    = '0;
         digits_in = '0;
      end else begin
         case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_PLAIN;
               case (b)
                  CH_LF: begin
                  end
                  CH_CR: mode_in = MODE_CR;
                  CH_N: begin bundle.data[0] = 8'h0a; n = 3'd1; end
                  CH_R: begin bundle.data[0] = 8'h0d; n = 3'd1; end
                  CH_A: begin bundle.data[0] = 8'h07; n = 3'd1; end
                  CH_T: begin bundle.data[0] = 8'h09; n = 3'd1; end
                  CH_B: begin bundle.data[0] = 8'h08; n = 3'd1; end
                  CH_V: begin bundle.data[0] = 8'h0b; n = 3'd1; end
                  CH_F: begin bundle.data[0] = 8'h0c; n = 3'd1; end
                  CH_X: begin
                     acc_in = '0; digits_in = 4'd2; mode_in = MODE_HEXX;
                  end
                  CH_LO_U: begin
                     acc_in = '0; digits_in = 4'd4; mode_in = MODE_HEXU;
                  end
                  CH_UP_U: begin
                     acc_in = '0; digits_in = 4'd8; mode_in = MODE_HEXU;
                  end
                  default: begin
                     if (b >= CH_ZERO && b <= CH_SEVEN) begin
                        acc_in    = {24'd0, 8'(b - CH_ZERO)};
                        digits_in = 4'd2;
                        mode_in   = MODE_OCT;
                     end else begin
                        bundle.data[0] = b;
                        n = 3'd1;
                     end
                  end
               endcase
            end
            MODE_CR: begin
               // optional LF after backslash-CR is swallowed
               mode_in = MODE_PLAIN;
               if (b != CH_LF) begin
                  if (b == CH_BACKSLASH) mode_in = MODE_ESC;
                  else begin
                     bundle.data[0] = b;
                     n = 3'd1;
                  end
               end
            end
            MODE_OCT: begin
               if (b >= CH_ZERO && b <= CH_SEVEN) begin
                  acc_in    = {24'd0, oct_val};
                  digits_in = dig_dec;
                  if (dig_dec == 4'd0) begin
                     bundle.data[0] = oct_val;
                     n = 3'd1;
                     mode_in   = MODE_PLAIN;
                     acc_in    = '0;
                     digits_in = '0;
                  end
               end else begin
                  // escape ended early: send its value, then take the byte as text
                  bundle.data[0] = acc_ff[7:0];
                  n = 3'd1;
                  mode_in   = MODE_PLAIN;
                  acc_in    = '0;
                  digits_in = '0;
                  if (b == CH_BACKSLASH) mode_in = MODE_ESC;
                  else begin
                     bundle.data[1] = b;
                     n = 3'd2;
                  end
               end
            end
            MODE_HEXX, MODE_HEXU: begin
               if (!hv[4]) begin
                  bundle.tail_valid = 1'b1;
                  bundle.tail_error = ERR_HEX;
                  mode_in   = MODE_DISCARD;
                  acc_in    = '0;
                  digits_in = '0;
               end else begin
                  acc_in    = u;
                  digits_in = dig_dec;
                  if (dig_dec == 4'd0) begin
                     if (mode_ff == MODE_HEXX) begin
                        bundle.data[0] = u[7:0];
                        n = 3'd1;
                     end else if (u <= 32'h7f) begin
                        bundle.data[0] = u[7:0];
                        n = 3'd1;
                     end else if (u <= 32'h7ff) begin
                        bundle.data[0] = 8'hc0 | {3'd0, u[10:6]};
                        bundle.data[1] = 8'h80 | {2'd0, u[5:0]};
                        n = 3'd2;
                     end else if (u <= 32'hffff) begin
                        bundle.data[0] = 8'he0 | {4'd0, u[15:12]};
                        bundle.data[1] = 8'h80 | {2'd0, u[11:6]};
                        bundle.data[2] = 8'h80 | {2'd0, u[5:0]};
                        n = 3'd3;
                     end else begin
                        bundle.data[0] = 8'hf0 | {5'd0, u[20:18]};
                        bundle.data[1] = 8'h80 | {2'd0, u[17:12]};
                        bundle.data[2] = 8'h80 | {2'd0, u[11:6]};
                        bundle.data[3] = 8'h80 | {2'd0, u[5:0]};
                        n = 3'd4;
                     end
                     mode_in   = MODE_PLAIN;
                     acc_in    = '0;
                     digits_in = '0;
                  end
               end
            end
            MODE_DISCARD: begin
            end
            default: begin
               mode_in = MODE_PLAIN;
               if (b == CH_BACKSLASH) mode_in = MODE_ESC;
               else begin
                  bundle.data[0] = b;
                  n = 3'd1;
               end
            end
         endcase
      end
      bundle.num_bytes = n;
   end

   // Only items that cause results go to the queue
   assign q_push = accept && (bundle.num_bytes != 3'd0 || bundle.tail_valid);
   assign q_data = bundle;

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLAIN;
         acc_ff    <= '0;
         digits_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
      end
   end

endmodule

// ----- rtl/sed_queue.sv -----
module sed_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sed_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output sed_pkg::bundle_type head,
   output logic                empty
);
   import sed_pkg::*;

   bundle_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/sed_back.sv -----
module sed_back (
   input  logic                clock,
   input  logic                reset,
   input  sed_pkg::bundle_type head,
   input  logic                q_empty,
   output logic                q_pop,
   sed_rsp_if.source           rsp_chan
);
   import sed_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic       done_ff, done_in;
   logic [1:0] err_ff, err_in;
   logic       load;
   logic [2:0] total;

   assign load  = !q_empty && (!valid_ff || rsp_chan.ready);
   assign total = head.num_bytes + {2'd0, head.tail_valid};
   assign q_pop = load && (idx_ff + 3'd1 == total);

   // Pick the next result of the head bundle
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      has_in   = has_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      if (valid_ff && rsp_chan.ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (idx_ff < head.num_bytes) begin
            byte_in = head.data[idx_ff[1:0]];
            has_in  = 1'b1;
            done_in = 1'b0;
            err_in  = ERR_NONE;
         end else begin
            byte_in = 8'd0;
            has_in  = 1'b0;
            done_in = head.tail_done;
            err_in  = head.tail_error;
         end
         idx_in = q_pop ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      has_ff  <= has_in;
      done_ff <= done_in;
      err_ff  <= err_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.has_byte    = has_ff;
   assign rsp_chan.string_done = done_ff;
   assign rsp_chan.error_code  = err_ff;

endmodule

// ----- rtl/string_escape_decoder.sv -----
// Path: the results of an item are written to a queue entry at its input transfer and
// are moved one at a time into the output register, which back-pressure can hold.
// Throughput: one input item per cycle while the queue is not full; the back end sends
// one result per cycle while the receiver is ready; the 4-entry queue buffers pending items.
// Reset (synchronous, active high) returns the decoder to plain text and empties
// the queue and output register.
module string_escape_decoder (
   input  logic      clock,
   input  logic      reset,
   sed_req_if.sink   req_chan,
   sed_rsp_if.source rsp_chan
);
   import sed_pkg::*;

   logic       q_push, q_pop, q_full, q_empty;
   bundle_type q_in, q_head;

   sed_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   sed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   sed_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- test/string_escape_decoder_tb.sv -----
`timescale 1ns / 1ps

module string_escape_decoder_tb;
   import sed_pkg::*;

   localparam logic       KIND_BYTE = 1'b0;
   localparam logic       KIND_END  = 1'b1;
   localparam logic [7:0] BACKSLASH = 8'h5c;
   localparam logic [7:0] LF        = 8'h0a;
   localparam logic [7:0] CR        = 8'h0d;
   localparam int         SETTLE_CYCLES = 8;

   // One result as seen on the rsp channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_done;
      logic [1:0] error_code;
   } decoded_type;

   // Tracks the unescape state, holds the bytes it predicts and checks results
   class unescape_scoreboard;
      mode_type    mode;
      logic [31:0] code;
      logic [3:0]  digits;
      decoded_type pending_decoded[$];
      int          failures;

      function new();
         clear();
         failures = 0;
      endfunction

      function void clear();
         mode   = MODE_PLAIN;
         code   = '0;
         digits = '0;
      endfunction

      static function int hex_value(logic [7:0] b);
         if (b >= "0" && b <= "9") return b - "0";
         if (b >= "A" && b <= "F") return b - "A" + 10;
         if (b >= "a" && b <= "f") return b - "a" + 10;
         return -1;
      endfunction

      function int outstanding();
         return pending_decoded.size();
      endfunction

      function void push(logic [7:0] b, logic has, logic done, logic [1:0] err);
         decoded_type d;
         d.out_byte    = b;
         d.has_byte    = has;
         d.string_done = done;
         d.error_code  = err;
         pending_decoded.push_back(d);
      endfunction

      function void push_byte(logic [7:0] b);
         push(b, 1'b1, 1'b0, ERR_NONE);
      endfunction

      // Byte seen in plain text: a backslash opens an escape
      function void plain(logic [7:0] b);
         if (b == BACKSLASH) mode = MODE_ESC;
         else push_byte(b);
      endfunction

      // Predict the results of one accepted input transfer
      function void note_transfer(logic kind, logic [7:0] b);
         int hv;
         if (kind == KIND_END) begin
            case (mode)
               MODE_ESC, MODE_HEXX, MODE_HEXU: push(8'h00, 1'b0, 1'b1, ERR_CUT);
               MODE_OCT: begin
                  push_byte(code[7:0]);
                  push(8'h00, 1'b0, 1'b1, ERR_NONE);
               end
               default: push(8'h00, 1'b0, 1'b1, ERR_NONE);
            endcase
            clear();
            return;
         end
         case (mode)
            MODE_ESC: begin
               mode = MODE_PLAIN;
               case (b)
                  LF: ;
                  CR: mode = MODE_CR;
                  "n": push_byte(8'h0a);
                  "r": push_byte(8'h0d);
                  "a": push_byte(8'h07);
                  "t": push_byte(8'h09);
                  "b": push_byte(8'h08);
                  "v": push_byte(8'h0b);
                  "f": push_byte(8'h0c);
                  "x": begin code = '0; digits = 4'd2; mode = MODE_HEXX; end
                  "u": begin code = '0; digits = 4'd4; mode = MODE_HEXU; end
                  "U": begin code = '0; digits = 4'd8; mode = MODE_HEXU; end
                  default: begin
                     if (b >= "0" && b <= "7") begin
                        code   = {29'h0, b[2:0]};
                        digits = 4'd2;
                        mode   = MODE_OCT;
                     end else begin
                        push_byte(b);
                     end
                  end
               endcase
            end
            MODE_CR: begin
               // optional LF after backslash-CR is swallowed
               mode = MODE_PLAIN;
               if (b != LF) plain(b);
            end
            MODE_OCT: begin
               if (b >= "0" && b <= "7") begin
                  code   = {24'h0, code[4:0], b[2:0]};
                  digits = digits - 4'd1;
                  if (digits == 4'd0) begin
                     push_byte(code[7:0]);
                     clear();
                  end
               end else begin
                  // short octal escape: flush value, then treat byte as text
                  push_byte(code[7:0]);
                  clear();
                  plain(b);
               end
            end
            MODE_HEXX, MODE_HEXU: begin
               hv = hex_value(b);
               if (hv < 0) begin
                  push(8'h00, 1'b0, 1'b0, ERR_HEX);
                  mode   = MODE_DISCARD;
                  code   = '0;
                  digits = '0;
               end else begin
                  code   = {code[27:0], hv[3:0]};
                  digits = digits - 4'd1;
                  if (digits == 4'd0) begin
                     if (mode == MODE_HEXX) begin
                        push_byte(code[7:0]);
                     end else if (code <= 32'h7f) begin
                        push_byte(code[7:0]);
                     end else if (code <= 32'h7ff) begin
                        push_byte({3'b110, code[10:6]});
                        push_byte({2'b10, code[5:0]});
                     end else if (code <= 32'hffff) begin
                        push_byte({4'b1110, code[15:12]});
                        push_byte({2'b10, code[11:6]});
                        push_byte({2'b10, code[5:0]});
                     end else begin
                        // four-byte form, also past the Unicode range
                        push_byte({5'b11110, code[20:18]});
                        push_byte({2'b10, code[17:12]});
                        push_byte({2'b10, code[11:6]});
                        push_byte({2'b10, code[5:0]});
                     end
                     clear();
                  end
               end
            end
            MODE_DISCARD: ;
            default: begin
               mode = MODE_PLAIN;
               plain(b);
            end
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_result(decoded_type got);
         decoded_type want;
         if (pending_decoded.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual %h/%b/%b/%0d", $time,
                     got.out_byte, got.has_byte, got.string_done, got.error_code);
            return;
         end
         want = pending_decoded.pop_front();
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("has_byte", want.has_byte, got.has_byte);
         compare_field("string_done", want.string_done, got.string_done);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic clock;
   logic reset;

   sed_req_if req_chan ();
   sed_rsp_if rsp_chan ();

   string_escape_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   unescape_scoreboard board = new();
   int src_idle_pct;
   int sink_idle_pct;
   int items_sent;

   always #1 clock = ~clock;

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.note_transfer(req_chan.kind, req_chan.in_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_result({rsp_chan.out_byte, rsp_chan.has_byte,
                                rsp_chan.string_done, rsp_chan.error_code});
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   // Drive one item and wait for its transfer; returns at a falling edge
   task automatic send_item(logic kind, logic [7:0] b, bit counted = 1'b1);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= kind;
      req_chan.in_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      if (counted) items_sent++;
   endtask

   // Hold off until every predicted result is out, then let the pipe settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return "0" + v;
      return ($urandom_range(1) ? "a" : "A") + v - 8'd10;
   endfunction

   task automatic send_hex(logic [31:0] value, int n);
      for (int i = n - 1; i >= 0; i--) send_item(KIND_BYTE, hex_char(value[4*i +: 4]));
   endtask

   // Code points spread over every UTF-8 length (four-byte ones only with eight digits)
   function automatic logic [31:0] random_code(int n);
      case ($urandom_range(4))
         0: return $urandom_range(32'h7f, 0);
         1: return $urandom_range(32'h7ff, 32'h80);
         2: return $urandom_range(32'hffff, 32'h800);
         3: return (n == 8) ? $urandom_range(32'h10ffff, 32'h10000) : $urandom_range(32'hffff, 0);
         default: return (n == 8) ? $urandom() : $urandom_range(32'hffff, 0);
      endcase
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (unescape_scoreboard::hex_value(b) >= 0);
      return b;
   endfunction

   // One random piece of string: mostly well-formed escapes, some broken ones
   task automatic send_random_token();
      int pick;
      int n;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_item(KIND_BYTE, 8'($urandom_range(255)));
      end else if (pick < 45) begin
         send_item(KIND_BYTE, BACKSLASH);
         case ($urandom_range(9))
            0: b = "n";
            1: b = "r";
            2: b = "a";
            3: b = "t";
            4: b = "b";
            5: b = "v";
            6: b = "f";
            7: b = BACKSLASH;
            default: b = 8'($urandom_range(255));
         endcase
         send_item(KIND_BYTE, b);
      end else if (pick < 55) begin
         send_item(KIND_BYTE, BACKSLASH);
         n = $urandom_range(3, 1);
         repeat (n) send_item(KIND_BYTE, 8'("0" + $urandom_range(7)));
         if (n < 3 && $urandom_range(1)) begin
            do b = 8'($urandom_range(255)); while (b >= "0" && b <= "7");
            send_item(KIND_BYTE, b);
         end
      end else if (pick < 63) begin
         send_item(KIND_BYTE, BACKSLASH);
         send_item(KIND_BYTE, "x");
         send_hex($urandom_range(255), 2);
      end else if (pick < 73) begin
         send_item(KIND_BYTE, BACKSLASH);
         send_item(KIND_BYTE, "u");
         send_hex(random_code(4), 4);
      end else if (pick < 83) begin
         send_item(KIND_BYTE, BACKSLASH);
         send_item(KIND_BYTE, "U");
         send_hex(random_code(8), 8);
      end else if (pick < 88) begin
         // line continuation, LF or CR with optional LF
         send_item(KIND_BYTE, BACKSLASH);
         if ($urandom_range(1)) begin
            send_item(KIND_BYTE, LF);
         end else begin
            send_item(KIND_BYTE, CR);
            if ($urandom_range(1)) send_item(KIND_BYTE, LF);
         end
      end else if (pick < 93) begin
         // bad hex digit, then discarded bytes up to the end
         send_item(KIND_BYTE, BACKSLASH);
         case ($urandom_range(2))
            0: begin b = "x"; n = 2; end
            1: begin b = "u"; n = 4; end
            default: begin b = "U"; n = 8; end
         endcase
         send_item(KIND_BYTE, b);
         repeat ($urandom_range(n - 1))
            send_item(KIND_BYTE, hex_char(4'($urandom_range(15))));
         send_item(KIND_BYTE, non_hex_byte());
         repeat ($urandom_range(3)) send_item(KIND_BYTE, 8'($urandom_range(255)), 1'b0);
         send_item(KIND_END, 8'($urandom_range(255)));
      end else begin
         // end of string, sometimes in the middle of an escape
         if ($urandom_range(1)) begin
            send_item(KIND_BYTE, BACKSLASH);
            case ($urandom_range(2))
               0: ;
               1: begin
                  case ($urandom_range(2))
                     0: begin b = "x"; n = 2; end
                     1: begin b = "u"; n = 4; end
                     default: begin b = "U"; n = 8; end
                  endcase
                  send_item(KIND_BYTE, b);
                  repeat ($urandom_range(n - 1))
                     send_item(KIND_BYTE, hex_char(4'($urandom_range(15))));
               end
               default: repeat ($urandom_range(2, 1))
                  send_item(KIND_BYTE, 8'("0" + $urandom_range(7)));
            endcase
         end
         send_item(KIND_END, 8'($urandom_range(255)));
      end
   endtask

   task automatic run_phase(int src_pct, int sink_pct, int target);
      int start;
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      start = items_sent;
      while (items_sent - start < target) send_random_token();
      send_item(KIND_END, 8'($urandom_range(255)));
      drain();
   endtask

   // Main sequence
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.kind    = KIND_BYTE;
      req_chan.in_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      src_idle_pct     = 11;
      sink_idle_pct    = 66;
      items_sent       = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Byte extremes, short octal, backslash-LF, backslash-CR at end
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'hff);
      send_item(KIND_BYTE, BACKSLASH);
      send_item(KIND_BYTE, "7");
      send_item(KIND_BYTE, "z");
      send_item(KIND_BYTE, BACKSLASH);
      send_item(KIND_BYTE, LF);
      send_item(KIND_BYTE, BACKSLASH);
      send_item(KIND_BYTE, CR);
      send_item(KIND_END, 8'hff);
      // Largest code point, then octal escape closed by end
      send_item(KIND_BYTE, BACKSLASH);
      send_item(KIND_BYTE, "U");
      send_hex(32'hffffffff, 8);
      send_item(KIND_BYTE, BACKSLASH);
      send_item(KIND_BYTE, "5");
      send_item(KIND_END, 8'h00);
      // Lone trailing backslash
      send_item(KIND_BYTE, BACKSLASH);
      send_item(KIND_END, 8'h00);
      // Bad hex digit, then a discarded byte
      send_item(KIND_BYTE, BACKSLASH);
      send_item(KIND_BYTE, "x");
      send_item(KIND_BYTE, "g");
      send_item(KIND_BYTE, 8'h41);
      send_item(KIND_END, 8'h00);
      drain();

      run_phase(11, 66, 45);
      run_phase(66, 11, 45);
      run_phase(0, 0, 45);

      if (board.failures == 0) begin
         $display("string_escape_decoder verification clean");
      end else begin
         $display("string_escape_decoder verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #200000;
      $display("string_escape_decoder verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sed_pkg.sv
rtl/sed_req_if.sv
rtl/sed_rsp_if.sv
rtl/sed_front.sv
rtl/sed_queue.sv
rtl/sed_back.sv
rtl/string_escape_decoder.sv
test/string_escape_decoder_tb.sv
